@@ rtl/bft3d_pkg.sv @@
// ----------------------------------------------------------------------------
// bft3d_pkg
// Shared types and constants of the 3D beam frame transform block.
// ----------------------------------------------------------------------------
package bft3d_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned COEF_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W      = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X,
    CFG_ROW_Y,
    CFG_ROW_Z,
    CFG_INV_LEN
  } cfg_reg_e;

  // Triad slot that closes a displacement set (node j rotation).
  localparam logic [1:0] SLOT_J_ROT = 2'd3;

  // Where a finished accumulation goes.
  typedef enum logic [2:0] {
    DST_TRIAD,
    DST_FA,
    DST_FB,
    DST_P,
    DST_Q,
    DST_OUT
  } dest_e;

  // Control that travels with a product into the accumulate stage.
  typedef struct packed {
    logic       valid;
    logic       chord;
    logic       first;
    logic       last;
    logic       hi;
    dest_e      dest;
    logic [1:0] idx;
    logic [1:0] grp;
  } acc_ctl_t;

endpackage

@@ rtl/beam_frame_transform_3d.sv @@
// ----------------------------------------------------------------------------
// beam_frame_transform_3d
// Rotates beam end triads into the local frame and builds basic deformations,
// or expands basic forces and rotates them back, on one shared multiplier.
// ----------------------------------------------------------------------------
// A displacement word rotates its triad into the local frame; slots 0..2 give
// no result, and slot 3 then scales the chords and gives the six deformations.
// A force word forms the chord terms and gives four results, one per expanded
// triad, the last flagged by is_last_o. No new word is taken while busy_o is high;
// meanwhile the single multiplier takes one product per cycle.
// Reset clears the sequencer and loads the identity frame and unit length.
module beam_frame_transform_3d
  import bft3d_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         kind_i,
  input  logic [1:0]                   slot_i,
  input  logic signed [DATA_WIDTH-1:0] val0_i,
  input  logic signed [DATA_WIDTH-1:0] val1_i,
  input  logic signed [DATA_WIDTH-1:0] val2_i,
  input  logic signed [DATA_WIDTH-1:0] val3_i,
  input  logic signed [DATA_WIDTH-1:0] val4_i,
  input  logic signed [DATA_WIDTH-1:0] val5_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [((3*COEF_WIDTH > DATA_WIDTH) ? 3*COEF_WIDTH : DATA_WIDTH)-1:0] cfg_wdata_i,
  output logic                         res_valid_o,
  output logic [1:0]                   out_slot_o,
  output logic                         is_last_o,
  output logic signed [DATA_WIDTH-1:0] res0_o,
  output logic signed [DATA_WIDTH-1:0] res1_o,
  output logic signed [DATA_WIDTH-1:0] res2_o,
  output logic signed [DATA_WIDTH-1:0] res3_o,
  output logic signed [DATA_WIDTH-1:0] res4_o,
  output logic signed [DATA_WIDTH-1:0] res5_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned CW    = COEF_WIDTH;
  localparam int unsigned DF    = DW / 2;
  localparam int unsigned DH    = DW - DF;
  localparam int unsigned CFRAC = CW - 2;
  localparam int unsigned RW    = 3 * CW;
  localparam int unsigned BW    = (CW > DH + 1) ? CW : DH + 1;
  localparam int unsigned AOW   = DW + 1;
  localparam int unsigned PW    = AOW + BW;
  localparam int unsigned AW    = (2 * DW + 3 > DW + CW + 3) ? 2 * DW + 3 : DW + CW + 3;
  localparam int unsigned EW    = DW + 2;

  localparam logic signed [AW-1:0] HALF_CH  = AW'(1) << (DF - 1);
  localparam logic signed [AW-1:0] HALF_DOT = AW'(1) << (CFRAC - 1);
  localparam logic signed [AW-1:0] DMAX_A   = (AW'(1) << (DW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] DMIN_A   = ~DMAX_A;
  localparam logic signed [AW-1:0] EMAX_A   = (AW'(1) << (EW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] EMIN_A   = ~EMAX_A;
  localparam logic signed [DW-1:0] DMIN_D   = {1'b1, {(DW-1){1'b0}}};

  localparam logic [RW-1:0] ROW_X_RST = RW'(1) << CFRAC;
  localparam logic [RW-1:0] ROW_Y_RST = RW'(1) << (CFRAC + CW);
  localparam logic [RW-1:0] ROW_Z_RST = RW'(1) << (CFRAC + 2 * CW);
  localparam logic [DW-1:0] INV_RST   = DW'(1) << DF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHORD,
    ST_DOT,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW-1:0] x);
    logic signed [DW-1:0] y;
    if (x > DMAX_A) begin
      y = DMAX_A[DW-1:0];
    end else if (x < DMIN_A) begin
      y = DMIN_A[DW-1:0];
    end else begin
      y = x[DW-1:0];
    end
    return y;
  endfunction

  function automatic logic signed [EW-1:0] sat_ew(input logic signed [AW-1:0] x);
    logic signed [EW-1:0] y;
    if (x > EMAX_A) begin
      y = EMAX_A[EW-1:0];
    end else if (x < EMIN_A) begin
      y = EMIN_A[EW-1:0];
    end else begin
      y = x[EW-1:0];
    end
    return y;
  endfunction

  function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] y;
    if (x == DMIN_D) begin
      y = ~DMIN_D;
    end else begin
      y = -x;
    end
    return y;
  endfunction

  // Configuration
  logic [RW-1:0] row_q [3];
  logic [DW-1:0] inv_q;

  // Sequencer
  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic [1:0] grp_q, grp_d;
  logic       kind_q;
  logic [1:0] slot_q;
  logic       accept;

  // Operands and shared datapath
  logic signed [DW-1:0]  v_q [6];
  logic signed [DW-1:0]  nv0_q, nv5_q;
  logic signed [AOW-1:0] ca_q, cb_q, ca_d, cb_d;
  logic signed [DW-1:0]  p_q, q_q, np_q, nq_q;
  logic signed [EW-1:0]  fa_q, fb_q;
  logic signed [DW-1:0]  t_q [4][3];
  logic signed [CW-1:0]  coef_w [3][3];
  logic signed [DW-1:0]  h_sel;
  logic signed [CW-1:0]  coef_sel;
  logic signed [AOW-1:0] mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  prod_q;
  acc_ctl_t              ctl_q, ctl_d;
  logic signed [AW-1:0]  acc_q;
  logic signed [AW-1:0]  acc_base, acc_add, acc_sum, acc_shr;
  logic signed [DW-1:0]  res_sat;
  logic signed [EW-1:0]  res_sat2;
  logic signed [DW-1:0]  defo [6];

  // Result registers
  logic                 valid_q;
  logic [1:0]           out_slot_q;
  logic                 is_last_q;
  logic signed [DW-1:0] res_q [6];

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign coef_w[r][k] = row_q[r][k*CW +: CW];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_X_RST;
      row_q[1] <= ROW_Y_RST;
      row_q[2] <= ROW_Z_RST;
      inv_q    <= INV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROW_X:   row_q[0] <= cfg_wdata_i[RW-1:0];
        CFG_ROW_Y:   row_q[1] <= cfg_wdata_i[RW-1:0];
        CFG_ROW_Z:   row_q[2] <= cfg_wdata_i[RW-1:0];
        CFG_INV_LEN: inv_q    <= cfg_wdata_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    grp_d   = grp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = kind_i ? ST_CHORD : ST_DOT;
          cnt_d   = '0;
          comp_d  = '0;
          grp_d   = '0;
        end
      end
      ST_CHORD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          cnt_d   = '0;
          state_d = kind_q ? ST_DOT : ST_DRAIN;
        end
      end
      ST_DOT: begin
        if (cnt_q == 2'd2) begin
          cnt_d = '0;
          if (comp_q == 2'd2) begin
            comp_d = '0;
            if (!kind_q) begin
              state_d = (slot_q == SLOT_J_ROT) ? ST_CHORD : ST_DRAIN;
            end else if (grp_q == 2'd3) begin
              state_d = ST_DRAIN;
            end else begin
              grp_d = grp_q + 2'd1;
            end
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = (!kind_q && slot_q == SLOT_J_ROT) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Expanded force triads: (-f0, p, -q), (-f5, f3, f1), (f0, -p, q), (f5, f4, f2).
  always_comb begin
    case ({grp_q, cnt_q})
      4'b0000: h_sel = nv0_q;
      4'b0001: h_sel = p_q;
      4'b0010: h_sel = nq_q;
      4'b0100: h_sel = nv5_q;
      4'b0101: h_sel = v_q[3];
      4'b0110: h_sel = v_q[1];
      4'b1000: h_sel = v_q[0];
      4'b1001: h_sel = np_q;
      4'b1010: h_sel = q_q;
      4'b1100: h_sel = v_q[5];
      4'b1101: h_sel = v_q[4];
      4'b1110: h_sel = v_q[2];
      default: h_sel = '0;
    endcase
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    coef_sel = '0;
    ctl_d    = '0;
    ctl_d.dest = DST_TRIAD;
    unique case (state_q)
      ST_CHORD: begin
        // The reciprocal length is split into two halves, low half first.
        mul_a = cnt_q[1] ? cb_q : ca_q;
        if (cnt_q[0]) begin
          mul_b = {{(BW-DH){1'b0}}, inv_q[DW-1:DF]};
        end else begin
          mul_b = {{(BW-DF){1'b0}}, inv_q[DF-1:0]};
        end
        ctl_d.valid = 1'b1;
        ctl_d.chord = 1'b1;
        ctl_d.first = ~cnt_q[0];
        ctl_d.last  = cnt_q[0];
        ctl_d.hi    = cnt_q[0];
        if (kind_q) begin
          ctl_d.dest = cnt_q[1] ? DST_Q : DST_P;
        end else begin
          ctl_d.dest = cnt_q[1] ? DST_FB : DST_FA;
        end
      end
      ST_DOT: begin
        if (kind_q) begin
          mul_a      = AOW'(h_sel);
          coef_sel   = coef_w[cnt_q][comp_q];
          ctl_d.dest = DST_OUT;
        end else begin
          mul_a      = AOW'(v_q[{1'b0, cnt_q}]);
          coef_sel   = coef_w[comp_q][cnt_q];
          ctl_d.dest = DST_TRIAD;
        end
        mul_b       = BW'(coef_sel);
        ctl_d.valid = 1'b1;
        ctl_d.first = (cnt_q == 2'd0);
        ctl_d.last  = (cnt_q == 2'd2);
        ctl_d.idx   = comp_q;
        ctl_d.grp   = grp_q;
      end
      default: ;
    endcase
  end

  // Chord operands are formed when the word is taken.
  always_comb begin
    if (kind_i) begin
      ca_d = AOW'(val1_i) + AOW'(val2_i);
      cb_d = AOW'(val3_i) + AOW'(val4_i);
    end else begin
      ca_d = AOW'(t_q[0][1]) - AOW'(t_q[2][1]);
      cb_d = AOW'(t_q[2][2]) - AOW'(t_q[0][2]);
    end
  end

  // Accumulate stage; rounding adds one half before the final shift.
  always_comb begin
    if (ctl_q.first) begin
      acc_base = ctl_q.chord ? HALF_CH : HALF_DOT;
    end else begin
      acc_base = acc_q;
    end
    acc_add  = ctl_q.hi ? (AW'(prod_q) <<< DF) : AW'(prod_q);
    acc_sum  = acc_base + acc_add;
    acc_shr  = ctl_q.chord ? (acc_sum >>> DF) : (acc_sum >>> CFRAC);
    res_sat  = sat_dw(acc_shr);
    res_sat2 = sat_ew(acc_shr);
  end

  // Local deformations from the four stored triads.
  always_comb begin
    defo[0] = sat_dw(AW'(t_q[2][0]) - AW'(t_q[0][0]));
    defo[1] = sat_dw(AW'(t_q[1][2]) + AW'(fa_q));
    defo[2] = sat_dw(AW'(t_q[3][2]) + AW'(fa_q));
    defo[3] = sat_dw(AW'(t_q[1][1]) + AW'(fb_q));
    defo[4] = sat_dw(AW'(t_q[3][1]) + AW'(fb_q));
    defo[5] = sat_dw(AW'(t_q[3][0]) - AW'(t_q[1][0]));
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q[0] <= val0_i;
      v_q[1] <= val1_i;
      v_q[2] <= val2_i;
      v_q[3] <= val3_i;
      v_q[4] <= val4_i;
      v_q[5] <= val5_i;
      nv0_q  <= neg_sat(val0_i);
      nv5_q  <= neg_sat(val5_i);
      ca_q   <= ca_d;
      cb_q   <= cb_d;
    end
    prod_q <= PW'(mul_a) * PW'(mul_b);
    if (ctl_q.valid) begin
      acc_q <= acc_sum;
      if (ctl_q.last) begin
        case (ctl_q.dest)
          DST_TRIAD: t_q[slot_q][ctl_q.idx] <= res_sat;
          DST_FA:    fa_q <= res_sat2;
          DST_FB:    fb_q <= res_sat2;
          DST_P:     p_q  <= res_sat;
          DST_Q:     q_q  <= res_sat;
          default: ;
        endcase
      end
    end
    // The negated chord terms are registered from their source, so they trail it.
    np_q <= neg_sat(p_q);
    nq_q <= neg_sat(q_q);
  end

  // Sequencer state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      comp_q     <= '0;
      grp_q      <= '0;
      kind_q     <= 1'b0;
      slot_q     <= '0;
      ctl_q      <= '0;
      valid_q    <= 1'b0;
      out_slot_q <= '0;
      is_last_q  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        res_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      grp_q   <= grp_d;
      ctl_q   <= ctl_d;
      valid_q <= 1'b0;
      if (accept) begin
        kind_q <= kind_i;
        slot_q <= slot_i;
      end
      if (ctl_q.valid && ctl_q.last && ctl_q.dest == DST_OUT) begin
        res_q[{1'b0, ctl_q.idx}] <= res_sat;
        if (ctl_q.idx == 2'd2) begin
          res_q[3]   <= '0;
          res_q[4]   <= '0;
          res_q[5]   <= '0;
          out_slot_q <= ctl_q.grp;
          is_last_q  <= (ctl_q.grp == 2'd3);
          valid_q    <= 1'b1;
        end
      end
      if (state_q == ST_EMIT) begin
        for (int i = 0; i < 6; i++) begin
          res_q[i] <= defo[i];
        end
        out_slot_q <= '0;
        is_last_q  <= 1'b1;
        valid_q    <= 1'b1;
      end
    end
  end

  assign res_valid_o = valid_q;
  assign out_slot_o  = out_slot_q;
  assign is_last_o   = is_last_q;
  assign res0_o      = res_q[0];
  assign res1_o      = res_q[1];
  assign res2_o      = res_q[2];
  assign res3_o      = res_q[3];
  assign res4_o      = res_q[4];
  assign res5_o      = res_q[5];

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for beam_frame_transform_3d. Displacement and force
// words are sent under several frames and reciprocal lengths. Directed words
// cover the reset frame, half-LSB rounding and saturating frames, and random
// phases follow. A bit-exact fixed-point predictor scores every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bft3d_pkg::*;

  localparam int DW            = DATA_WIDTH_DEF;
  localparam int CW            = COEF_WIDTH_DEF;
  localparam int DFRAC         = DW / 2;
  localparam int CFRAC         = CW - 2;
  localparam int CFG_W         = (3 * CW > DW) ? 3 * CW : DW;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 48;
  localparam int MAX_REPORTS   = 10;

  localparam logic KIND_DISP  = 1'b0;
  localparam logic KIND_FORCE = 1'b1;

  localparam logic [DW-1:0] POS_FULL = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_FULL = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE      = 1 << DFRAC;
  localparam logic [DW-1:0] NEG_ONE  = -(1 << DFRAC);

  localparam logic [CW-1:0] COS_HALF     = CW'(1 << (CFRAC - 1));
  localparam logic [CW-1:0] COS_NEG_HALF = CW'(-(1 << (CFRAC - 1)));
  localparam logic [CW-1:0] COS_POS_FULL = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] COS_NEG_FULL = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [DW-1:0]  word_t;
  typedef logic signed [127:0]   wide_t;

  localparam wide_t WORD_MAX = (wide_t'(1) <<< (DW - 1)) - 1;
  localparam wide_t WORD_MIN = -(wide_t'(1) <<< (DW - 1));

  typedef struct packed {
    logic                kind;
    logic [1:0]          slot;
    logic [5:0][DW-1:0]  val;
  } beam_word_t;

  typedef struct packed {
    logic [1:0]          slot;
    logic                last;
    logic [5:0][DW-1:0]  res;
  } beam_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  logic                 kind_i      = 1'b0;
  logic [1:0]           slot_i      = '0;
  word_t                val0_i      = '0;
  word_t                val1_i      = '0;
  word_t                val2_i      = '0;
  word_t                val3_i      = '0;
  word_t                val4_i      = '0;
  word_t                val5_i      = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 res_valid_o;
  logic [1:0]           out_slot_o;
  logic                 is_last_o;
  word_t                res0_o;
  word_t                res1_o;
  word_t                res2_o;
  word_t                res3_o;
  word_t                res4_o;
  word_t                res5_o;

  // Predictor copy of the configuration and of the rotated triad store.
  logic [3*CW-1:0] frame_rows [3];
  logic [DW-1:0]   inv_length;
  word_t           local_triads [4][3];
  beam_result_t    pending_results [$];
  int              mismatches  = 0;
  int              idle_cycles = 0;

  beam_frame_transform_3d #(
    .DATA_WIDTH (DW),
    .COEF_WIDTH (CW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .slot_i      (slot_i),
    .val0_i      (val0_i),
    .val1_i      (val1_i),
    .val2_i      (val2_i),
    .val3_i      (val3_i),
    .val4_i      (val4_i),
    .val5_i      (val5_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .out_slot_o  (out_slot_o),
    .is_last_o   (is_last_o),
    .res0_o      (res0_o),
    .res1_o      (res1_o),
    .res2_o      (res2_o),
    .res3_o      (res3_o),
    .res4_o      (res4_o),
    .res5_o      (res5_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic word_t clamp_word(input wide_t x);
    if (x > WORD_MAX) begin
      return POS_FULL;
    end
    if (x < WORD_MIN) begin
      return NEG_FULL;
    end
    return x[DW-1:0];
  endfunction

  function automatic wide_t cosine(input int r, input int k);
    logic signed [CW-1:0] c;
    c = frame_rows[r][k*CW +: CW];
    return c;
  endfunction

  // Rotates a triad by the frame, or by its transpose, rounding half up.
  function automatic word_t frame_apply(input wide_t a0, input wide_t a1, input wide_t a2,
                                        input int sel, input bit transposed);
    wide_t acc;
    acc = wide_t'(1) <<< (CFRAC - 1);
    if (transposed) begin
      acc += a0 * cosine(0, sel) + a1 * cosine(1, sel) + a2 * cosine(2, sel);
    end else begin
      acc += a0 * cosine(sel, 0) + a1 * cosine(sel, 1) + a2 * cosine(sel, 2);
    end
    return clamp_word(acc >>> CFRAC);
  endfunction

  // Scales by the reciprocal length; the result is held within +-2^DW.
  function automatic wide_t chord_scale(input wide_t a);
    wide_t inv_w;
    wide_t lim;
    wide_t q;
    inv_w = inv_length;
    lim   = wide_t'(1) <<< DW;
    q     = (a * inv_w + (wide_t'(1) <<< (DFRAC - 1))) >>> DFRAC;
    if (q > lim) begin
      q = lim;
    end
    if (q < -lim) begin
      q = -lim;
    end
    return q;
  endfunction

  task automatic predict_word(input beam_word_t w);
    wide_t        v [6];
    wide_t        t [4][3];
    wide_t        h [4][3];
    wide_t        fa;
    wide_t        fb;
    wide_t        p;
    wide_t        q;
    beam_result_t r;
    for (int k = 0; k < 6; k++) begin
      v[k] = $signed(w.val[k]);
    end
    if (w.kind == KIND_DISP) begin
      for (int c = 0; c < 3; c++) begin
        local_triads[w.slot][c] = frame_apply(v[0], v[1], v[2], c, 1'b0);
      end
      if (w.slot == SLOT_J_ROT) begin
        for (int s = 0; s < 4; s++) begin
          for (int c = 0; c < 3; c++) begin
            t[s][c] = local_triads[s][c];
          end
        end
        fa = chord_scale(t[0][1] - t[2][1]);
        fb = chord_scale(t[2][2] - t[0][2]);
        r.slot   = 2'd0;
        r.last   = 1'b1;
        r.res[0] = clamp_word(t[2][0] - t[0][0]);
        r.res[1] = clamp_word(t[1][2] + fa);
        r.res[2] = clamp_word(t[3][2] + fa);
        r.res[3] = clamp_word(t[1][1] + fb);
        r.res[4] = clamp_word(t[3][1] + fb);
        r.res[5] = clamp_word(t[3][0] - t[1][0]);
        pending_results.push_back(r);
      end
    end else begin
      p = clamp_word(chord_scale(v[1] + v[2]));
      q = clamp_word(chord_scale(v[3] + v[4]));
      h[0][0] = clamp_word(-v[0]);
      h[0][1] = p;
      h[0][2] = clamp_word(-q);
      h[1][0] = clamp_word(-v[5]);
      h[1][1] = v[3];
      h[1][2] = v[1];
      h[2][0] = v[0];
      h[2][1] = clamp_word(-p);
      h[2][2] = q;
      h[3][0] = v[5];
      h[3][1] = v[4];
      h[3][2] = v[2];
      for (int k = 0; k < 4; k++) begin
        r.slot = 2'(k);
        r.last = (k == 3);
        for (int i = 0; i < 3; i++) begin
          r.res[i] = frame_apply(h[k][0], h[k][1], h[k][2], i, 1'b1);
        end
        r.res[3] = '0;
        r.res[4] = '0;
        r.res[5] = '0;
        pending_results.push_back(r);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result scoring and watchdog
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [DW-1:0] want_v,
                               input logic [DW-1:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    beam_result_t       want;
    logic [5:0][DW-1:0] got;
    if (rst_ni && res_valid_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result word with nothing pending", '0, DW'(out_slot_o));
      end else begin
        want = pending_results.pop_front();
        got  = {res5_o, res4_o, res3_o, res2_o, res1_o, res0_o};
        if (out_slot_o !== want.slot) begin
          note_mismatch("out_slot", DW'(want.slot), DW'(out_slot_o));
        end
        if (is_last_o !== want.last) begin
          note_mismatch("is_last", DW'(want.last), DW'(is_last_o));
        end
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want.res[i]) begin
            note_mismatch($sformatf("res%0d", i), want.res[i], got[i]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || res_valid_o === 1'b1 || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_word(input beam_word_t w);
    start_i <= 1'b1;
    kind_i  <= w.kind;
    slot_i  <= w.slot;
    val0_i  <= w.val[0];
    val1_i  <= w.val[1];
    val2_i  <= w.val[2];
    val3_i  <= w.val[3];
    val4_i  <= w.val[4];
    val5_i  <= w.val[5];
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    predict_word(w);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Always advances the clock before it returns, so start is never lowered and raised
  // again within one time step.
  task automatic wait_results_drained();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ROW_X:   frame_rows[0] = data[3*CW-1:0];
      CFG_ROW_Y:   frame_rows[1] = data[3*CW-1:0];
      CFG_ROW_Z:   frame_rows[2] = data[3*CW-1:0];
      CFG_INV_LEN: inv_length    = data[DW-1:0];
      default: ;
    endcase
  endtask

  // Displacement words for slots 0..2 give no result, so the block may still
  // be busy once the queue is empty: let it settle before reconfiguring.
  task automatic load_frame(input logic [3*CW-1:0] rx, input logic [3*CW-1:0] ry,
                            input logic [3*CW-1:0] rz, input logic [CFG_W-1:0] inv_word);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_ROW_X, rx);
    write_reg(CFG_ROW_Y, ry);
    write_reg(CFG_ROW_Z, rz);
    write_reg(CFG_INV_LEN, inv_word);
    cfg_we_i <= 1'b0;
  endtask

  function automatic beam_word_t make_word(input logic kind, input logic [1:0] slot,
                                           input logic [DW-1:0] a, input logic [DW-1:0] b,
                                           input logic [DW-1:0] c, input logic [DW-1:0] d,
                                           input logic [DW-1:0] e, input logic [DW-1:0] f);
    beam_word_t w;
    w.kind = kind;
    w.slot = slot;
    w.val  = {f, e, d, c, b, a};
    return w;
  endfunction

  function automatic logic [DW-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return POS_FULL;
      1:       return NEG_FULL;
      2, 3, 4: return $urandom_range(0, 2097151) - 1048576;
      default: return $urandom();
    endcase
  endfunction

  function automatic beam_word_t random_word(input logic kind, input logic [1:0] slot);
    beam_word_t w;
    w.kind = kind;
    w.slot = slot;
    for (int k = 0; k < 6; k++) begin
      w.val[k] = random_value();
    end
    return w;
  endfunction

  function automatic int random_gap();
    int d;
    d = $urandom_range(0, 99);
    if (d < 55) begin
      return 0;
    end
    if (d < 85) begin
      return $urandom_range(1, 3);
    end
    if (d < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CW-1:0] random_cosine(input int mode);
    case (mode)
      0: return CW'($urandom_range(0, 32768) - 16384);
      1: return CW'($urandom());
      default: begin
        case ($urandom_range(0, 2))
          0:       return COS_POS_FULL;
          1:       return COS_NEG_FULL;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // The upper write data bits are noise; the length register keeps DW bits.
  function automatic logic [CFG_W-1:0] random_inv_word();
    logic [CFG_W-1:0] w;
    w = CFG_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 4))
      0:       w[DW-1:0] = '0;
      1:       w[DW-1:0] = '1;
      2:       w[DW-1:0] = $urandom_range(1, 1 << (DFRAC + 2));
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_frame();
    send_word(make_word(KIND_DISP, 2'd0, POS_FULL, NEG_FULL, '0,
                        $urandom(), $urandom(), $urandom()));
    send_word(make_word(KIND_DISP, 2'd1, '1, 32'd1, POS_FULL, '0, '0, '0));
    pause_sender(2);
    send_word(make_word(KIND_DISP, 2'd2, NEG_FULL, POS_FULL, '1, '0, '0, '0));
    send_word(make_word(KIND_DISP, SLOT_J_ROT, ONE, NEG_ONE, NEG_FULL,
                        POS_FULL, NEG_FULL, '1));
    // Negating the most negative force saturates; the slot bits are ignored.
    send_word(make_word(KIND_FORCE, 2'd3, NEG_FULL, POS_FULL, POS_FULL,
                        NEG_FULL, NEG_FULL, NEG_FULL));
    send_word(make_word(KIND_FORCE, 2'd2, '0, '0, '0, '0, '0, '0));
    send_word(make_word(KIND_FORCE, 2'd1, ONE, 32'd2, -32'sd3, NEG_ONE, 32'd5, ONE));
  endtask

  task automatic test_half_rounding();
    load_frame({16'h0000, COS_NEG_HALF, COS_HALF},
               {COS_NEG_HALF, COS_HALF, 16'h0000},
               {COS_HALF, 16'h0000, COS_NEG_HALF},
               {16'hFFFF, 32'h0000_8000});
    send_word(make_word(KIND_DISP, 2'd0, 32'd1, '0, '0, '0, '0, '0));
    send_word(make_word(KIND_DISP, 2'd1, '1, '0, 32'd3, '0, '0, '0));
    send_word(make_word(KIND_DISP, 2'd2, 32'd3, -32'sd3, 32'd1, '0, '0, '0));
    send_word(make_word(KIND_DISP, SLOT_J_ROT, -32'sd3, 32'd1, '1, '0, '0, '0));
    send_word(make_word(KIND_FORCE, 2'd0, 32'd1, '1, 32'd2, -32'sd3, 32'd1, '0));
  endtask

  task automatic test_saturating_frames();
    load_frame({3{COS_POS_FULL}}, {3{COS_POS_FULL}}, {3{COS_POS_FULL}},
               {16'h0000, 32'hFFFF_FFFF});
    send_word(make_word(KIND_DISP, 2'd0, POS_FULL, POS_FULL, POS_FULL, '0, '0, '0));
    send_word(make_word(KIND_DISP, 2'd1, NEG_FULL, POS_FULL, NEG_FULL, '0, '0, '0));
    send_word(make_word(KIND_DISP, 2'd2, NEG_FULL, NEG_FULL, NEG_FULL, '0, '0, '0));
    send_word(make_word(KIND_DISP, SLOT_J_ROT, ONE, POS_FULL, 32'd7, '0, '0, '0));
    send_word(make_word(KIND_FORCE, 2'd0, POS_FULL, POS_FULL, POS_FULL,
                        NEG_FULL, NEG_FULL, POS_FULL));
    load_frame({3{COS_NEG_FULL}}, {3{COS_NEG_FULL}}, {3{COS_NEG_FULL}}, '0);
    send_word(make_word(KIND_DISP, SLOT_J_ROT, NEG_ONE, 32'd5, POS_FULL, '0, '0, '0));
    send_word(make_word(KIND_FORCE, 2'd1, NEG_FULL, NEG_FULL, NEG_FULL,
                        POS_FULL, POS_FULL, NEG_FULL));
    send_word(make_word(KIND_DISP, 2'd0, NEG_FULL, NEG_FULL, NEG_FULL, '0, '0, '0));
    send_word(make_word(KIND_DISP, SLOT_J_ROT, POS_FULL, NEG_FULL, ONE, '0, '0, '0));
  endtask

  // Mostly complete displacement sets and force words, with stray slots mixed
  // in so that sets get broken off midway.
  task automatic run_random_phase(input int n_items);
    int sent;
    int choice;
    bit steady;
    sent   = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (sent < n_items) begin
      choice = $urandom_range(0, 99);
      if (choice < 60) begin
        for (int s = 0; s < 4; s++) begin
          send_word(random_word(KIND_DISP, 2'(s)));
          sent++;
          pause_sender(steady ? 0 : random_gap());
        end
      end else if (choice < 88) begin
        send_word(random_word(KIND_FORCE, 2'($urandom_range(0, 3))));
        sent++;
        pause_sender(steady ? 0 : random_gap());
      end else begin
        send_word(random_word(KIND_DISP, 2'($urandom_range(0, 3))));
        sent++;
        pause_sender(steady ? 0 : random_gap());
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_results_drained();
      end
    end
  endtask

  task automatic test_random_frames();
    logic [CW-1:0] c [9];
    int            mode;
    for (int phase = 0; phase < 5; phase++) begin
      mode = (phase == 4) ? 2 : (phase % 2);
      for (int k = 0; k < 9; k++) begin
        c[k] = random_cosine(mode);
      end
      load_frame({c[2], c[1], c[0]}, {c[5], c[4], c[3]}, {c[8], c[7], c[6]},
                 random_inv_word());
      run_random_phase(17);
    end
  endtask

  initial begin
    // Out of reset the block holds the identity frame and unit length.
    for (int r = 0; r < 3; r++) begin
      frame_rows[r]                = '0;
      frame_rows[r][r*CW + CFRAC] = 1'b1;
    end
    inv_length        = '0;
    inv_length[DFRAC] = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_frame();
    test_half_rounding();
    test_saturating_frames();
    test_random_frames();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
